FILE: rtl/clipwin_pkg.sv
// ----------------------------------------------------------------------------
// clipwin_pkg: shared constants, types and helpers for the window clipper
// Coordinate widths, outcode bits, register indexes, controller states.
// ----------------------------------------------------------------------------
package clipwin_pkg;

    localparam int COORD_BITS = 15;
    localparam int FRAC_BITS  = 8;
    localparam int LIM_W      = 13;
    localparam int OUT_W      = 32;
    localparam int CODE_W     = 4;
    localparam int CFG_IDX_W  = 1;

    // signed window edge, +-half size
    localparam int EDGE_W = LIM_W + 1;
    // spans and offsets: difference of a coordinate and an edge or coordinate
    localparam int SPAN_W = ((COORD_BITS > EDGE_W) ? COORD_BITS : EDGE_W) + 1;
    localparam int MAG_W  = SPAN_W;
    localparam int PROD_W = 2 * MAG_W;
    localparam int NUM_W  = PROD_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    // fixed point intersection value, room for the 2^40 clamp and the base
    localparam int VW     = ((NUM_W > 41) ? NUM_W : 41) + 2;

    localparam logic [VW-1:0]        BIG_MAG = VW'(1) << 40;
    localparam logic signed [VW-1:0] SAT_HI  = VW'(64'sd2147483647);
    localparam logic signed [VW-1:0] SAT_LO  = -SAT_HI - VW'(1);

    localparam logic [LIM_W-1:0] HALF_WIDTH_RESET  = LIM_W'(320);
    localparam logic [LIM_W-1:0] HALF_HEIGHT_RESET = LIM_W'(240);

    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CODE_W-1:0] OC_INSIDE = 4'd0;
    localparam logic [CODE_W-1:0] OC_LEFT   = 4'd1;
    localparam logic [CODE_W-1:0] OC_RIGHT  = 4'd2;
    localparam logic [CODE_W-1:0] OC_BOTTOM = 4'd4;
    localparam logic [CODE_W-1:0] OC_TOP    = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_DIV,
        ST_EVAL,
        ST_OUT
    } state_t;

    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [VW-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[OUT_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[OUT_W-1:0];
        else
            r = v[OUT_W-1:0];
        return r;
    endfunction

    function automatic logic signed [VW-1:0] scale(input logic signed [VW-1:0] b);
        return b <<< FRAC_BITS;
    endfunction

    function automatic logic [MAG_W-1:0] mag(input logic signed [SPAN_W-1:0] v);
        logic signed [SPAN_W-1:0] n;
        n = -v;
        return v[SPAN_W-1] ? unsigned'(n) : unsigned'(v);
    endfunction

endpackage

FILE: rtl/clipwin_if.sv
// ----------------------------------------------------------------------------
// clipwin_if: request channels of the window clipper
// Segment input, clip result output and register write channel.
// ----------------------------------------------------------------------------
interface clipwin_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [clipwin_pkg::COORD_BITS-1:0] start_x;
    logic signed [clipwin_pkg::COORD_BITS-1:0] start_y;
    logic signed [clipwin_pkg::COORD_BITS-1:0] end_x;
    logic signed [clipwin_pkg::COORD_BITS-1:0] end_y;
    logic [clipwin_pkg::CODE_W-1:0]           start_code;
    logic [clipwin_pkg::CODE_W-1:0]           end_code;

    modport source (output valid, start_x, start_y, end_x, end_y, start_code, end_code,
                    input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, start_code, end_code,
                  output ready);
endinterface

interface clipwin_out_if;
    logic                                valid;
    logic                                ready;
    logic                                draw;
    logic signed [clipwin_pkg::OUT_W-1:0] new_x;
    logic signed [clipwin_pkg::OUT_W-1:0] new_y;
    logic [clipwin_pkg::CODE_W-1:0]      clip_side;

    modport source (output valid, draw, new_x, new_y, clip_side, input ready);
    modport sink (input valid, draw, new_x, new_y, clip_side, output ready);
endinterface

interface clipwin_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [clipwin_pkg::CFG_IDX_W-1:0] index;
    logic [clipwin_pkg::LIM_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/clipwin_div.sv
// ----------------------------------------------------------------------------
// clipwin_div: radix-2 restoring divider
// One quotient bit per cycle; numerator shifts out as quotient shifts in.
// ----------------------------------------------------------------------------
module clipwin_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [clipwin_pkg::NUM_W-1:0]   num,
    input  logic [clipwin_pkg::MAG_W-1:0]   den,
    output logic                            done,
    output logic [clipwin_pkg::NUM_W-1:0]   quo
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [clipwin_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [clipwin_pkg::MAG_W-1:0] rem_reg, rem_next;
    logic [clipwin_pkg::MAG_W-1:0] den_reg, den_next;
    logic [clipwin_pkg::NUM_W-1:0] sh_reg, sh_next;

    logic [clipwin_pkg::MAG_W:0] trial;
    logic [clipwin_pkg::MAG_W:0] diff;
    logic                        ge;

    always_comb
    begin
        trial     = {rem_reg, sh_reg[clipwin_pkg::NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        sh_next   = sh_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = clipwin_pkg::CNT_W'(clipwin_pkg::NUM_W);
            rem_next  = '0;
            den_next  = den;
            sh_next   = num;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[clipwin_pkg::MAG_W-1:0] : trial[clipwin_pkg::MAG_W-1:0];
            sh_next  = {sh_reg[clipwin_pkg::NUM_W-2:0], ge};
            cnt_next = cnt_reg - clipwin_pkg::CNT_W'(1);
            if (cnt_reg == clipwin_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        sh_reg  <= sh_next;
    end

    assign done = done_reg;
    assign quo  = sh_reg;

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> den != '0)
        else $error("divider started with zero divisor");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < den_reg)
        else $error("partial remainder not below divisor");

endmodule

FILE: rtl/clip_line_endpoint_to_window.sv
// ----------------------------------------------------------------------------
// clip_line_endpoint_to_window: one-end line clipper against a centered window
// Rejects on shared outcode bits, otherwise moves the end point onto the edge
// named by its outcode, with 1/256 pixel intersections and held outputs.
// ----------------------------------------------------------------------------
// One segment request is taken at a time. Trivial cases (shared outcode bit,
// inside end, zero span, unused codes) go from the decide state straight to
// the output state. Each edge intersection passes the multiply state, which
// starts the divider on the span*offset product, the radix-2 restoring
// divider at one quotient bit a cycle, its done flag and the evaluate state,
// which forms and tests the intersection. Edge codes need one intersection,
// a corner code that misses its vertical edge needs two. The next request
// is taken the cycle after the result register is loaded, so requests are
// taken only after the last result is formed; a result still waiting in
// the output register holds the next one in the output state. Register
// writes are taken at any time, one per cycle, and belong between segments.
module clip_line_endpoint_to_window (
    input  logic           clk,
    input  logic           rst_n,
    clipwin_cfg_if.sink    cfg,
    clipwin_in_if.sink     seg,
    clipwin_out_if.source  res
);

    clipwin_pkg::state_t state_reg, state_next;

    logic [clipwin_pkg::LIM_W-1:0] hw_reg, hw_next;
    logic [clipwin_pkg::LIM_W-1:0] hh_reg, hh_next;

    logic signed [clipwin_pkg::COORD_BITS-1:0] sx_reg, sx_next;
    logic signed [clipwin_pkg::COORD_BITS-1:0] sy_reg, sy_next;
    logic signed [clipwin_pkg::COORD_BITS-1:0] ex_reg, ex_next;
    logic signed [clipwin_pkg::COORD_BITS-1:0] ey_reg, ey_next;
    logic [clipwin_pkg::CODE_W-1:0]            sc_reg, sc_next;
    logic [clipwin_pkg::CODE_W-1:0]            ec_reg, ec_next;

    logic                                       second_reg, second_next;
    logic signed [clipwin_pkg::COORD_BITS-1:0]  base_reg, base_next;
    logic signed [clipwin_pkg::SPAN_W-1:0]      span_reg, span_next;
    logic signed [clipwin_pkg::SPAN_W-1:0]      off_reg, off_next;
    logic signed [clipwin_pkg::SPAN_W-1:0]      den_reg, den_next;
    logic                                       neg_reg, neg_next;

    logic signed [clipwin_pkg::OUT_W-1:0] held_x_reg, held_x_next;
    logic signed [clipwin_pkg::OUT_W-1:0] held_y_reg, held_y_next;
    logic [clipwin_pkg::CODE_W-1:0]       held_side_reg, held_side_next;
    logic                                 draw_reg, draw_next;

    logic                                 out_valid_reg, out_valid_next;
    logic                                 out_draw_reg, out_draw_next;
    logic signed [clipwin_pkg::OUT_W-1:0] out_x_reg, out_x_next;
    logic signed [clipwin_pkg::OUT_W-1:0] out_y_reg, out_y_next;
    logic [clipwin_pkg::CODE_W-1:0]       out_side_reg, out_side_next;

    logic                             div_start;
    logic                             div_done;
    logic [clipwin_pkg::NUM_W-1:0]    div_num;
    logic [clipwin_pkg::MAG_W-1:0]    div_den;
    logic [clipwin_pkg::NUM_W-1:0]    div_quo;
    logic [clipwin_pkg::PROD_W-1:0]   prod;

    logic signed [clipwin_pkg::SPAN_W-1:0] dx, dy, off_x, off_y;
    logic signed [clipwin_pkg::EDGE_W-1:0] hw_s, hh_s, xe, ye;
    logic                                  edge_v, edge_h, in_win;
    logic [clipwin_pkg::LIM_W-1:0]         lim;
    logic signed [clipwin_pkg::VW-1:0]     lim_s, qm, v;
    logic [clipwin_pkg::VW-1:0]            q_ext;

    clipwin_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // geometry of the latched segment
    always_comb
    begin
        dx     = clipwin_pkg::SPAN_W'(ex_reg) - clipwin_pkg::SPAN_W'(sx_reg);
        dy     = clipwin_pkg::SPAN_W'(ey_reg) - clipwin_pkg::SPAN_W'(sy_reg);
        hw_s   = signed'({1'b0, hw_reg});
        hh_s   = signed'({1'b0, hh_reg});
        xe     = ec_reg[0] ? -hw_s : hw_s;
        ye     = ec_reg[2] ? -hh_s : hh_s;
        off_x  = clipwin_pkg::SPAN_W'(xe) - clipwin_pkg::SPAN_W'(sx_reg);
        off_y  = clipwin_pkg::SPAN_W'(ye) - clipwin_pkg::SPAN_W'(sy_reg);
        edge_v = (ec_reg == clipwin_pkg::OC_LEFT) || (ec_reg == clipwin_pkg::OC_RIGHT);
        edge_h = (ec_reg == clipwin_pkg::OC_BOTTOM) || (ec_reg == clipwin_pkg::OC_TOP);

        prod    = clipwin_pkg::PROD_W'(clipwin_pkg::mag(span_reg))
                * clipwin_pkg::PROD_W'(clipwin_pkg::mag(off_reg));
        div_num = {prod, clipwin_pkg::FRAC_BITS'(0)};
        div_den = clipwin_pkg::mag(den_reg);

        // quotient clamp at 2^40, then signed intersection value
        q_ext = clipwin_pkg::VW'(div_quo);
        qm    = signed'((q_ext >= clipwin_pkg::BIG_MAG) ? clipwin_pkg::BIG_MAG : q_ext);
        v     = clipwin_pkg::scale(clipwin_pkg::VW'(base_reg)) + (neg_reg ? -qm : qm);

        lim    = second_reg ? hw_reg : hh_reg;
        lim_s  = clipwin_pkg::scale(clipwin_pkg::VW'(signed'({1'b0, lim})));
        in_win = (v <= lim_s) && (v >= -lim_s);
    end

    always_comb
    begin
        state_next     = state_reg;
        hw_next        = hw_reg;
        hh_next        = hh_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        sc_next        = sc_reg;
        ec_next        = ec_reg;
        second_next    = second_reg;
        base_next      = base_reg;
        span_next      = span_reg;
        off_next       = off_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        held_x_next    = held_x_reg;
        held_y_next    = held_y_reg;
        held_side_next = held_side_reg;
        draw_next      = draw_reg;
        out_valid_next = out_valid_reg;
        out_draw_next  = out_draw_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_side_next  = out_side_reg;
        div_start      = 1'b0;

        if (cfg.valid)
        begin
            if (cfg.index == clipwin_pkg::REG_HALF_WIDTH)
                hw_next = cfg.data;
            if (cfg.index == clipwin_pkg::REG_HALF_HEIGHT)
                hh_next = cfg.data;
        end

        if (out_valid_reg && res.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            clipwin_pkg::ST_IDLE:
            begin
                if (seg.valid)
                begin
                    sx_next    = seg.start_x;
                    sy_next    = seg.start_y;
                    ex_next    = seg.end_x;
                    ey_next    = seg.end_y;
                    sc_next    = seg.start_code;
                    ec_next    = seg.end_code;
                    draw_next  = 1'b1;
                    state_next = clipwin_pkg::ST_DECIDE;
                end
            end
            clipwin_pkg::ST_DECIDE:
            begin
                state_next = clipwin_pkg::ST_OUT;
                if ((sc_reg & ec_reg) != clipwin_pkg::OC_INSIDE)
                    draw_next = 1'b0;
                else
                begin
                    case (ec_reg)
                        clipwin_pkg::OC_INSIDE:
                        begin
                            held_x_next    = clipwin_pkg::sat32(
                                clipwin_pkg::scale(clipwin_pkg::VW'(ex_reg)));
                            held_y_next    = clipwin_pkg::sat32(
                                clipwin_pkg::scale(clipwin_pkg::VW'(ey_reg)));
                            held_side_next = clipwin_pkg::OC_INSIDE;
                        end
                        clipwin_pkg::OC_LEFT, clipwin_pkg::OC_RIGHT,
                        clipwin_pkg::OC_LEFT | clipwin_pkg::OC_BOTTOM,
                        clipwin_pkg::OC_RIGHT | clipwin_pkg::OC_BOTTOM,
                        clipwin_pkg::OC_LEFT | clipwin_pkg::OC_TOP,
                        clipwin_pkg::OC_RIGHT | clipwin_pkg::OC_TOP:
                        begin
                            if (dx == '0)
                                draw_next = 1'b0;
                            else
                            begin
                                second_next = 1'b0;
                                base_next   = sy_reg;
                                span_next   = dy;
                                off_next    = off_x;
                                den_next    = dx;
                                state_next  = clipwin_pkg::ST_MUL;
                            end
                        end
                        clipwin_pkg::OC_BOTTOM, clipwin_pkg::OC_TOP:
                        begin
                            if (dy == '0)
                                draw_next = 1'b0;
                            else
                            begin
                                second_next = 1'b1;
                                base_next   = sx_reg;
                                span_next   = dx;
                                off_next    = off_y;
                                den_next    = dy;
                                state_next  = clipwin_pkg::ST_MUL;
                            end
                        end
                        default:
                        begin
                            // codes with both left and right or both bottom and top: kept, nothing changes
                        end
                    endcase
                end
            end
            clipwin_pkg::ST_MUL:
            begin
                div_start  = 1'b1;
                neg_next   = ((span_reg[clipwin_pkg::SPAN_W-1] ^ off_reg[clipwin_pkg::SPAN_W-1])
                             ^ den_reg[clipwin_pkg::SPAN_W-1])
                             && (span_reg != '0) && (off_reg != '0);
                state_next = clipwin_pkg::ST_DIV;
            end
            clipwin_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = clipwin_pkg::ST_EVAL;
            end
            clipwin_pkg::ST_EVAL:
            begin
                state_next = clipwin_pkg::ST_OUT;
                if (!second_reg)
                begin
                    held_y_next = clipwin_pkg::sat32(v);
                    if (in_win || edge_v)
                        held_x_next = clipwin_pkg::sat32(
                            clipwin_pkg::scale(clipwin_pkg::VW'(xe)));
                    if (in_win)
                        held_side_next = ec_reg & (clipwin_pkg::OC_LEFT | clipwin_pkg::OC_RIGHT);
                    else if (edge_v || dy == '0)
                        draw_next = 1'b0;
                    else
                    begin
                        // corner missed its vertical edge: try the horizontal one
                        second_next = 1'b1;
                        base_next   = sx_reg;
                        span_next   = dx;
                        off_next    = off_y;
                        den_next    = dy;
                        state_next  = clipwin_pkg::ST_MUL;
                    end
                end
                else
                begin
                    held_x_next = clipwin_pkg::sat32(v);
                    if (in_win || edge_h)
                        held_y_next = clipwin_pkg::sat32(
                            clipwin_pkg::scale(clipwin_pkg::VW'(ye)));
                    if (in_win)
                        held_side_next = ec_reg & (clipwin_pkg::OC_BOTTOM | clipwin_pkg::OC_TOP);
                    else
                        draw_next = 1'b0;
                end
            end
            clipwin_pkg::ST_OUT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_draw_next  = draw_reg;
                    out_x_next     = held_x_reg;
                    out_y_next     = held_y_reg;
                    out_side_next  = held_side_reg;
                    state_next     = clipwin_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = clipwin_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= clipwin_pkg::ST_IDLE;
            hw_reg        <= clipwin_pkg::HALF_WIDTH_RESET;
            hh_reg        <= clipwin_pkg::HALF_HEIGHT_RESET;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            held_side_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hw_reg        <= hw_next;
            hh_reg        <= hh_next;
            held_x_reg    <= held_x_next;
            held_y_reg    <= held_y_next;
            held_side_reg <= held_side_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        ex_reg       <= ex_next;
        ey_reg       <= ey_next;
        sc_reg       <= sc_next;
        ec_reg       <= ec_next;
        second_reg   <= second_next;
        base_reg     <= base_next;
        span_reg     <= span_next;
        off_reg      <= off_next;
        den_reg      <= den_next;
        neg_reg      <= neg_next;
        draw_reg     <= draw_next;
        out_draw_reg <= out_draw_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_side_reg <= out_side_next;
    end

    assign cfg.ready     = 1'b1;
    assign seg.ready     = (state_reg == clipwin_pkg::ST_IDLE);
    assign res.valid     = out_valid_reg;
    assign res.draw      = out_draw_reg;
    assign res.new_x     = out_x_reg;
    assign res.new_y     = out_y_reg;
    assign res.clip_side = out_side_reg;

    a_side_single_edge: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(held_side_reg))
        else $error("held clip side names more than one edge");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == clipwin_pkg::ST_DIV)
        else $error("divider finished outside the divide state");

    a_request_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (seg.valid && seg.ready) |=> state_reg == clipwin_pkg::ST_DECIDE)
        else $error("accepted segment did not start processing");

endmodule

FILE: tb/clip_line_endpoint_to_window_tb.sv
// ----------------------------------------------------------------------------
// clip_line_endpoint_to_window_tb: self-checking bench for the window clipper
// Drives segment requests with random gaps, stalls the result side at random,
// predicts every result from its own outcode/intersection model, compares
// field by field and steps the window size through several settings.
// ----------------------------------------------------------------------------
module clip_line_endpoint_to_window_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint FIX_ONE    = longint'(1) << clipwin_pkg::FRAC_BITS;
    localparam int     LONG_HOLD  = 300;
    localparam int     IDLE_LIMIT = 4000;
    localparam int     MAX_COORD  = (1 << (clipwin_pkg::COORD_BITS - 1)) - 1;

    typedef struct {
        logic signed [clipwin_pkg::COORD_BITS-1:0] start_x;
        logic signed [clipwin_pkg::COORD_BITS-1:0] start_y;
        logic signed [clipwin_pkg::COORD_BITS-1:0] end_x;
        logic signed [clipwin_pkg::COORD_BITS-1:0] end_y;
        logic [clipwin_pkg::CODE_W-1:0]            start_code;
        logic [clipwin_pkg::CODE_W-1:0]            end_code;
    } segment_t;

    typedef struct {
        logic                                 draw;
        logic signed [clipwin_pkg::OUT_W-1:0] new_x;
        logic signed [clipwin_pkg::OUT_W-1:0] new_y;
        logic [clipwin_pkg::CODE_W-1:0]       clip_side;
    } clip_result_t;

    logic clk;
    logic rst_n;

    clipwin_cfg_if cfg_if();
    clipwin_in_if  seg_if();
    clipwin_out_if res_if();

    clip_line_endpoint_to_window dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .seg   (seg_if),
        .res   (res_if)
    );

    // window registers and held outputs as the block should have them
    logic [clipwin_pkg::LIM_W-1:0]        win_half_width  = clipwin_pkg::HALF_WIDTH_RESET;
    logic [clipwin_pkg::LIM_W-1:0]        win_half_height = clipwin_pkg::HALF_HEIGHT_RESET;
    logic signed [clipwin_pkg::OUT_W-1:0] last_x    = '0;
    logic signed [clipwin_pkg::OUT_W-1:0] last_y    = '0;
    logic [clipwin_pkg::CODE_W-1:0]       last_side = clipwin_pkg::OC_INSIDE;

    segment_t     seg_pending[$];
    clip_result_t clip_expect_q[$];
    segment_t     seg_cur;
    int           seg_gap;
    bit           seg_steady   = 1'b0;
    int           res_wait;
    bit           res_steady   = 1'b0;
    int           seg_total    = 0;
    int           results_seen = 0;
    int           fail_count   = 0;
    int           idle_cycles  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [clipwin_pkg::OUT_W-1:0] to_q32(input longint v);
        if (v > longint'(32'sh7fffffff))
            return 32'sh7fffffff;
        else if (v < -longint'(32'sh7fffffff) - 1)
            return 32'sh80000000;
        return clipwin_pkg::OUT_W'(v);
    endfunction

    // base*2^F plus span*off*2^F/den truncated toward zero, clamped at 2^40
    function automatic longint edge_cross(input longint base, input longint span,
                                          input longint off, input longint den);
        longint unsigned p, ad, q0, r, qm;
        bit neg;
        p  = longint'(span < 0 ? -span : span) * longint'(off < 0 ? -off : off);
        ad = den < 0 ? -den : den;
        q0 = p / ad;
        r  = p % ad;
        neg = ((span < 0) != (off < 0)) != (den < 0);
        if (span == 0 || off == 0)
            neg = 1'b0;
        if (q0 >= (longint'(1) << (40 - clipwin_pkg::FRAC_BITS)))
            qm = longint'(1) << 40;
        else
            qm = (q0 << clipwin_pkg::FRAC_BITS) + ((r << clipwin_pkg::FRAC_BITS) / ad);
        return base * FIX_ONE + (neg ? -longint'(qm) : longint'(qm));
    endfunction

    function automatic bit beyond(input longint v, input longint lim);
        return v > lim * FIX_ONE || v < -lim * FIX_ONE;
    endfunction

    function automatic clip_result_t clip_segment(input segment_t s);
        clip_result_t r;
        longint sx, sy, ex, ey, dx, dy, hw, hh, xe, ye, v;
        logic [clipwin_pkg::CODE_W-1:0] sc, ec;
        sx = s.start_x;
        sy = s.start_y;
        ex = s.end_x;
        ey = s.end_y;
        sc = s.start_code;
        ec = s.end_code;
        hw = win_half_width;
        hh = win_half_height;
        dx = ex - sx;
        dy = ey - sy;
        xe = ((ec & clipwin_pkg::OC_LEFT) != 0) ? -hw : hw;
        ye = ((ec & clipwin_pkg::OC_BOTTOM) != 0) ? -hh : hh;
        r.draw = 1'b1;
        if ((sc & ec) != 0)
            r.draw = 1'b0;
        else
        begin
            case (ec)
                clipwin_pkg::OC_INSIDE:
                begin
                    last_x    = to_q32(ex * FIX_ONE);
                    last_y    = to_q32(ey * FIX_ONE);
                    last_side = clipwin_pkg::OC_INSIDE;
                end
                clipwin_pkg::OC_LEFT, clipwin_pkg::OC_RIGHT:
                begin
                    if (dx == 0)
                        r.draw = 1'b0;
                    else
                    begin
                        last_x = to_q32(xe * FIX_ONE);
                        v = edge_cross(sy, dy, xe - sx, dx);
                        last_y = to_q32(v);
                        if (beyond(v, hh))
                            r.draw = 1'b0;
                        else
                            last_side = ec;
                    end
                end
                clipwin_pkg::OC_BOTTOM, clipwin_pkg::OC_TOP:
                begin
                    if (dy == 0)
                        r.draw = 1'b0;
                    else
                    begin
                        last_y = to_q32(ye * FIX_ONE);
                        v = edge_cross(sx, dx, ye - sy, dy);
                        last_x = to_q32(v);
                        if (beyond(v, hw))
                            r.draw = 1'b0;
                        else
                            last_side = ec;
                    end
                end
                clipwin_pkg::OC_LEFT | clipwin_pkg::OC_BOTTOM,
                clipwin_pkg::OC_RIGHT | clipwin_pkg::OC_BOTTOM,
                clipwin_pkg::OC_LEFT | clipwin_pkg::OC_TOP,
                clipwin_pkg::OC_RIGHT | clipwin_pkg::OC_TOP:
                begin
                    if (dx == 0)
                        r.draw = 1'b0;
                    else
                    begin
                        v = edge_cross(sy, dy, xe - sx, dx);
                        last_y = to_q32(v);
                        if (!beyond(v, hh))
                        begin
                            last_x    = to_q32(xe * FIX_ONE);
                            last_side = ec & (clipwin_pkg::OC_LEFT | clipwin_pkg::OC_RIGHT);
                        end
                        else if (dy == 0)
                            r.draw = 1'b0;
                        else
                        begin
                            v = edge_cross(sx, dx, ye - sy, dy);
                            last_x = to_q32(v);
                            if (beyond(v, hw))
                                r.draw = 1'b0;
                            else
                            begin
                                last_y    = to_q32(ye * FIX_ONE);
                                last_side = ec & (clipwin_pkg::OC_BOTTOM | clipwin_pkg::OC_TOP);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        r.new_x     = last_x;
        r.new_y     = last_y;
        r.clip_side = last_side;
        return r;
    endfunction

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic [clipwin_pkg::CODE_W-1:0] outcode_of(input int x, input int y);
        logic [clipwin_pkg::CODE_W-1:0] c;
        c = clipwin_pkg::OC_INSIDE;
        if (x < -int'(win_half_width))
            c |= clipwin_pkg::OC_LEFT;
        else if (x > int'(win_half_width))
            c |= clipwin_pkg::OC_RIGHT;
        if (y < -int'(win_half_height))
            c |= clipwin_pkg::OC_BOTTOM;
        else if (y > int'(win_half_height))
            c |= clipwin_pkg::OC_TOP;
        return c;
    endfunction

    function automatic int pick_gap(inout bit steady);
        if ($urandom_range(0, 31) == 0)
            steady = !steady;
        return steady ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic segment_t random_segment();
        segment_t s;
        int kind, hw, hh, rx, ry, sx, sy, ex, ey;
        hw = win_half_width;
        hh = win_half_height;
        rx = (2 * hw + 16 > MAX_COORD) ? MAX_COORD : 2 * hw + 16;
        ry = (2 * hh + 16 > MAX_COORD) ? MAX_COORD : 2 * hh + 16;
        kind = $urandom_range(0, 99);
        if (kind < 12)
        begin
            s.start_x    = clipwin_pkg::COORD_BITS'($urandom);
            s.start_y    = clipwin_pkg::COORD_BITS'($urandom);
            s.end_x      = clipwin_pkg::COORD_BITS'($urandom);
            s.end_y      = clipwin_pkg::COORD_BITS'($urandom);
            s.start_code = clipwin_pkg::CODE_W'($urandom);
            s.end_code   = clipwin_pkg::CODE_W'($urandom);
        end
        else
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                sx = rand_between(-hw, hw);
                sy = rand_between(-hh, hh);
            end
            else
            begin
                sx = rand_between(-rx, rx);
                sy = rand_between(-ry, ry);
            end
            ex = rand_between(-rx, rx);
            ey = rand_between(-ry, ry);
            if (kind < 22)
            begin
                if ($urandom_range(0, 1))
                    ex = sx;
                else
                    ey = sy;
            end
            else if (kind < 32)
            begin
                if ($urandom_range(0, 1))
                    ex = ($urandom_range(0, 1) ? hw : -hw) + rand_between(-2, 2);
                else
                    ey = ($urandom_range(0, 1) ? hh : -hh) + rand_between(-2, 2);
            end
            s.start_x    = clipwin_pkg::COORD_BITS'(sx);
            s.start_y    = clipwin_pkg::COORD_BITS'(sy);
            s.end_x      = clipwin_pkg::COORD_BITS'(ex);
            s.end_y      = clipwin_pkg::COORD_BITS'(ey);
            s.start_code = outcode_of(sx, sy);
            s.end_code   = outcode_of(ex, ey);
            if (kind >= 90)
            begin
                s.start_code ^= clipwin_pkg::CODE_W'($urandom);
                s.end_code   ^= clipwin_pkg::CODE_W'($urandom);
            end
        end
        return s;
    endfunction

    task automatic add_segment(input int sx, input int sy, input int ex, input int ey,
                               input logic [clipwin_pkg::CODE_W-1:0] sc,
                               input logic [clipwin_pkg::CODE_W-1:0] ec);
        segment_t s;
        s.start_x    = clipwin_pkg::COORD_BITS'(sx);
        s.start_y    = clipwin_pkg::COORD_BITS'(sy);
        s.end_x      = clipwin_pkg::COORD_BITS'(ex);
        s.end_y      = clipwin_pkg::COORD_BITS'(ey);
        s.start_code = sc;
        s.end_code   = ec;
        seg_pending.push_back(s);
        seg_total++;
    endtask

    task automatic add_random(input int count);
        repeat (count) seg_pending.push_back(random_segment());
        seg_total += count;
    endtask

    task automatic write_window_reg(input logic [clipwin_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [clipwin_pkg::LIM_W-1:0] val);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (!(cfg_if.valid && cfg_if.ready));
        cfg_if.valid <= 1'b0;
        if (idx == clipwin_pkg::REG_HALF_WIDTH)
            win_half_width = val;
        else
            win_half_height = val;
    endtask

    // every request handed to the driver has produced its result
    task automatic wait_drained();
        while (results_seen < seg_total)
            @(posedge clk);
    endtask

    task automatic run_window(input logic [clipwin_pkg::LIM_W-1:0] hw,
                              input logic [clipwin_pkg::LIM_W-1:0] hh,
                              input int count);
        write_window_reg(clipwin_pkg::REG_HALF_WIDTH, hw);
        write_window_reg(clipwin_pkg::REG_HALF_HEIGHT, hh);
        add_random(count);
        wait_drained();
    endtask

    task automatic check_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : segment_driver
        logic next_valid;
        if (!rst_n)
        begin
            seg_gap = 0;
            seg_if.valid <= 1'b0;
        end
        else
        begin
            next_valid = seg_if.valid;
            if (seg_if.valid && seg_if.ready)
            begin
                clip_expect_q.push_back(clip_segment(seg_cur));
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (seg_gap > 0)
                    seg_gap--;
                else if (seg_pending.size() != 0)
                begin
                    seg_cur = seg_pending.pop_front();
                    seg_if.start_x    <= seg_cur.start_x;
                    seg_if.start_y    <= seg_cur.start_y;
                    seg_if.end_x      <= seg_cur.end_x;
                    seg_if.end_y      <= seg_cur.end_y;
                    seg_if.start_code <= seg_cur.start_code;
                    seg_if.end_code   <= seg_cur.end_code;
                    next_valid = 1'b1;
                    seg_gap = pick_gap(seg_steady);
                end
            end
            seg_if.valid <= next_valid;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        clip_result_t want;
        if (!rst_n)
        begin
            res_wait = 0;
            res_if.ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (clip_expect_q.size() == 0)
                begin
                    $error("clip result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = clip_expect_q.pop_front();
                    check_field("draw", want.draw, res_if.draw);
                    check_field("new_x", want.new_x, res_if.new_x);
                    check_field("new_y", want.new_y, res_if.new_y);
                    check_field("clip_side", want.clip_side, res_if.clip_side);
                end
                results_seen++;
                // long back-pressure: block fills up and must stall its input
                if (results_seen == 30 || results_seen == 700)
                    res_wait = LONG_HOLD;
                else
                    res_wait = pick_gap(res_steady);
            end
            if (res_wait > 0)
            begin
                res_wait--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = clipwin_pkg::REG_HALF_WIDTH;
        cfg_if.data  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed cases at the reset half sizes of 320 x 240
        add_segment(-16384, -16384, 16383, 16383,
                    clipwin_pkg::OC_LEFT | clipwin_pkg::OC_BOTTOM,
                    clipwin_pkg::OC_RIGHT | clipwin_pkg::OC_TOP);
        add_segment(16383, -16384, -16384, 16383,
                    clipwin_pkg::OC_RIGHT | clipwin_pkg::OC_BOTTOM,
                    clipwin_pkg::OC_LEFT | clipwin_pkg::OC_TOP);
        add_segment(-400, 0, -500, 10, clipwin_pkg::OC_LEFT, clipwin_pkg::OC_LEFT);
        add_segment(0, 0, 100, -50, clipwin_pkg::OC_INSIDE, clipwin_pkg::OC_INSIDE);
        add_segment(0, 0, 16383, -16384, clipwin_pkg::OC_INSIDE, clipwin_pkg::OC_INSIDE);
        add_segment(0, 0, -1000, 100, clipwin_pkg::OC_INSIDE, clipwin_pkg::OC_LEFT);
        add_segment(0, 0, 1000, -300, clipwin_pkg::OC_INSIDE, clipwin_pkg::OC_RIGHT);
        add_segment(0, 0, 50, -1000, clipwin_pkg::OC_INSIDE, clipwin_pkg::OC_BOTTOM);
        add_segment(10, 10, -100, 1000, clipwin_pkg::OC_INSIDE, clipwin_pkg::OC_TOP);
        add_segment(0, 0, -7, 3, clipwin_pkg::OC_INSIDE, clipwin_pkg::OC_LEFT);
        add_segment(-500, 0, -500, 300, clipwin_pkg::OC_INSIDE, clipwin_pkg::OC_LEFT);
        add_segment(0, 300, 100, 300, clipwin_pkg::OC_INSIDE, clipwin_pkg::OC_TOP);
        add_segment(0, 0, 400, 2000, clipwin_pkg::OC_INSIDE, clipwin_pkg::OC_RIGHT);
        add_segment(0, 0, -2000, -300, clipwin_pkg::OC_INSIDE, clipwin_pkg::OC_BOTTOM);
        add_segment(0, 0, 400, -250, clipwin_pkg::OC_INSIDE,
                    clipwin_pkg::OC_RIGHT | clipwin_pkg::OC_BOTTOM);
        add_segment(0, 0, -350, 1000, clipwin_pkg::OC_INSIDE,
                    clipwin_pkg::OC_LEFT | clipwin_pkg::OC_TOP);
        add_segment(-400, 0, -400, -400, clipwin_pkg::OC_INSIDE,
                    clipwin_pkg::OC_LEFT | clipwin_pkg::OC_BOTTOM);
        add_segment(0, 1000, 2000, 1000, clipwin_pkg::OC_INSIDE,
                    clipwin_pkg::OC_RIGHT | clipwin_pkg::OC_TOP);
        add_segment(0, 5000, -2000, -3000, clipwin_pkg::OC_INSIDE,
                    clipwin_pkg::OC_LEFT | clipwin_pkg::OC_BOTTOM);
        add_segment(0, 0, 500, 0, clipwin_pkg::OC_INSIDE,
                    clipwin_pkg::OC_LEFT | clipwin_pkg::OC_RIGHT);
        add_segment(0, 0, 0, 500, clipwin_pkg::OC_INSIDE,
                    clipwin_pkg::OC_BOTTOM | clipwin_pkg::OC_TOP);
        add_segment(0, 0, 500, 500, clipwin_pkg::OC_INSIDE,
                    clipwin_pkg::OC_LEFT | clipwin_pkg::OC_RIGHT
                    | clipwin_pkg::OC_BOTTOM | clipwin_pkg::OC_TOP);
        add_segment(-1, -1, -1, -1,
                    clipwin_pkg::OC_LEFT | clipwin_pkg::OC_RIGHT
                    | clipwin_pkg::OC_BOTTOM | clipwin_pkg::OC_TOP,
                    clipwin_pkg::OC_LEFT | clipwin_pkg::OC_RIGHT
                    | clipwin_pkg::OC_BOTTOM | clipwin_pkg::OC_TOP);
        add_segment(0, 0, 320, 240, clipwin_pkg::OC_INSIDE, clipwin_pkg::OC_INSIDE);
        add_random(300);
        wait_drained();

        run_window(clipwin_pkg::LIM_W'(1), clipwin_pkg::LIM_W'(1), 200);
        run_window(clipwin_pkg::LIM_W'(8191), clipwin_pkg::LIM_W'(8191), 200);
        run_window(clipwin_pkg::LIM_W'(1), clipwin_pkg::LIM_W'(8191), 150);
        run_window(clipwin_pkg::LIM_W'(8191), clipwin_pkg::LIM_W'(1), 150);
        run_window(clipwin_pkg::LIM_W'($urandom_range(1, 400)),
                   clipwin_pkg::LIM_W'($urandom_range(1, 400)), 200);
        run_window(clipwin_pkg::LIM_W'($urandom_range(1, 8191)),
                   clipwin_pkg::LIM_W'($urandom_range(1, 8191)), 200);

        repeat (120) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
